@@ hw/rtl/tsr_pkg.sv @@
// Shared types, constants and widths for the slip resistance core.
`default_nettype none
package tsr_pkg;
    localparam int unsigned NUM_SLIP_DEF = 12;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned DENS_W       = 33;
    localparam int unsigned TOT_W        = 39;
    localparam int unsigned S_W          = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SELF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BARRIER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURGERS = 3'd4;

    localparam logic [15:0] SELF_RST    = 16'd4096;
    localparam logic [15:0] LATENT_RST  = 16'd819;
    localparam logic [15:0] BARRIER_RST = 16'd1229;
    localparam logic [19:0] SHEAR_RST   = 20'd79731;

    typedef struct packed {
        logic [15:0] self_factor;
        logic [15:0] latent_factor;
        logic [15:0] barrier_factor;
        logic [19:0] modulus_mpa;
        logic [31:0] burgers_vec;
    } cfg_t;

    // one slip system job handed from front to back
    typedef struct packed {
        logic [DENS_W-1:0] own;
        logic [TOT_W-1:0]  total;
        logic [3:0]        sys;
        logic              last;
    } job_t;
endpackage
`default_nettype wire

@@ hw/rtl/taylor_slip_resistance_core.sv @@
// Top level of the Taylor slip resistance core.
// Input words on s_axis: one slip system per word, tlast on the final one.
// After tlast the front end reads the stored sums and queues one job per
// system; the back end works each job through two multiply stages, a
// 32-step bitwise square root and a split final multiply, and takes no
// new job until the last result has entered its output register. Input
// is held off (s_axis_tready low) while the set is being issued. Results
// leave on m_axis in system order, tlast on the final one.
// A stalled receiver holds the output register; the back end then waits.
// Reset clears counters and the total and restores register defaults.
// Configuration writes (cfg_wr_en, cfg_wr_index, cfg_wr_data) only when idle.
`default_nettype none
module taylor_slip_resistance_core #(
    parameter int unsigned NUM_SLIP = tsr_pkg::NUM_SLIP_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata, // mobile, immobile
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [39:0]                        m_axis_tdata, // slip_system, resistance, saturated
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [tsr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import tsr_pkg::*;
    cfg_t cfg_reg;
    job_t f_job, q_job;
    logic f_v, f_r, q_v, q_r;
    logic [3:0]  r_sys;
    logic [31:0] r_val;
    logic        r_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.self_factor    <= SELF_RST;
            cfg_reg.latent_factor  <= LATENT_RST;
            cfg_reg.barrier_factor <= BARRIER_RST;
            cfg_reg.modulus_mpa    <= SHEAR_RST;
            cfg_reg.burgers_vec    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SELF:    cfg_reg.self_factor    <= cfg_wr_data[15:0];
                REG_LATENT:  cfg_reg.latent_factor  <= cfg_wr_data[15:0];
                REG_BARRIER: cfg_reg.barrier_factor <= cfg_wr_data[15:0];
                REG_SHEAR:   cfg_reg.modulus_mpa    <= cfg_wr_data[19:0];
                REG_BURGERS: cfg_reg.burgers_vec    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    tsr_front #(.NUM_SLIP(NUM_SLIP)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .mob(s_axis_tdata[31:0]), .imm(s_axis_tdata[63:32]), .last(s_axis_tlast),
        .job_valid(f_v), .job_ready(f_r), .job(f_job)
    );
    tsr_queue #(.DEPTH(4)) u_queue (
        .aclk, .aresetn,
        .wr_valid(f_v), .wr_ready(f_r), .wr_job(f_job),
        .rd_valid(q_v), .rd_ready(q_r), .rd_job(q_job)
    );
    tsr_back u_back (
        .aclk, .aresetn, .cfg(cfg_reg),
        .job_valid(q_v), .job_ready(q_r), .job(q_job),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_sys(r_sys), .res_value(r_val), .res_sat(r_sat), .res_last(m_axis_tlast)
    );
    assign m_axis_tdata = {3'd0, r_sat, r_val, r_sys};

    no_input_while_issuing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken during issue");
    last_is_top_system: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (r_sys == 4'(NUM_SLIP - 1)))
        else $error("last flag on wrong system");
endmodule
`default_nettype wire

@@ hw/rtl/tsr_front.sv @@
// Front end: loads densities, keeps the total and issues one job per system.
`default_nettype none
module tsr_front #(
    parameter int unsigned NUM_SLIP = tsr_pkg::NUM_SLIP_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [31:0]  mob,
    input  wire logic [31:0]  imm,
    input  wire logic         last,
    output logic              job_valid,
    input  wire logic         job_ready,
    output tsr_pkg::job_t     job
);
    import tsr_pkg::*;
    localparam int unsigned IDX_W = (NUM_SLIP > 1) ? $clog2(NUM_SLIP) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_SLIP + 1);
    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_SLIP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLIP - 1);

    logic [DENS_W-1:0] store_mem [NUM_SLIP];
    logic [CNT_W-1:0]  load_reg, load_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              issue_reg, issue_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DENS_W-1:0] rd_reg;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_loaded_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TOT_W-1:0]  rd_total_reg;
    logic [DENS_W-1:0] sum;
    logic              take, rd_go;

    assign sum      = {1'b0, mob} + {1'b0, imm};
    assign in_ready = !issue_reg;
    assign take     = in_valid && in_ready;
    // read one entry per cycle while the output slot is free
    assign rd_go    = issue_reg && (!rd_valid_reg || job_ready);

    always_comb begin
        load_next     = load_reg;
        total_next    = total_reg;
        issue_next    = issue_reg;
        idx_next      = idx_reg;
        rd_valid_next = rd_valid_reg;
        if (rd_valid_reg && job_ready) rd_valid_next = 1'b0;
        if (take) begin
            if (load_reg < NUM_C) begin
                load_next  = load_reg + 1'b1;
                total_next = total_reg + TOT_W'(sum);
            end
            if (last) begin
                issue_next = 1'b1;
                idx_next   = '0;
            end
        end
        if (rd_go) begin
            rd_valid_next = 1'b1;
            idx_next      = idx_reg + 1'b1;
            // drop the set counters when the read sweep ends
            if (idx_reg == LAST_IDX) begin
                issue_next = 1'b0;
                load_next  = '0;
                total_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg     <= '0;
            total_reg    <= '0;
            issue_reg    <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            load_reg     <= load_next;
            total_reg    <= total_next;
            issue_reg    <= issue_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && load_reg < NUM_C) store_mem[load_reg[IDX_W-1:0]] <= sum;
        if (rd_go) begin
            rd_reg        <= store_mem[idx_reg];
            rd_idx_reg    <= idx_reg;
            rd_loaded_reg <= CNT_W'(idx_reg) < load_reg;
            // hold the set total with the job, the next set may start loading
            rd_total_reg  <= total_reg;
        end
    end

    always_comb begin
        job.own   = rd_loaded_reg ? rd_reg : '0;
        job.total = rd_total_reg;
        job.sys   = 4'(rd_idx_reg);
        job.last  = rd_idx_reg == LAST_IDX;
    end
    assign job_valid = rd_valid_reg;
endmodule
`default_nettype wire

@@ hw/rtl/tsr_queue.sv @@
// Short job queue between front and back.
`default_nettype none
module tsr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  tsr_pkg::job_t  wr_job,
    output logic           rd_valid,
    input  wire logic      rd_ready,
    output tsr_pkg::job_t  rd_job
);
    import tsr_pkg::*;
    localparam int unsigned PW = $clog2(DEPTH);
    job_t          q_mem [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != (PW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_job   = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end
    always_ff @(posedge aclk) begin
        if (wr) q_mem[wp_reg] <= wr_job;
    end
endmodule
`default_nettype wire

@@ hw/rtl/tsr_back.sv @@
// Back end: hardening sum, barrier scaling, bitwise square root, final scaling.
`default_nettype none
module tsr_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  tsr_pkg::cfg_t    cfg,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  tsr_pkg::job_t    job,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [3:0]       res_sys,
    output logic [31:0]      res_value,
    output logic             res_sat,
    output logic             res_last
);
    import tsr_pkg::*;
    localparam logic [3:0] ST_IDLE = 4'd0, ST_M1 = 4'd1, ST_M2 = 4'd2, ST_SUM = 4'd3,
                           ST_D = 4'd4, ST_D2 = 4'd5, ST_SQ = 4'd6, ST_G = 4'd7,
                           ST_R = 4'd8, ST_OUT = 4'd9;

    logic [3:0]       st_reg, st_next;
    logic [TOT_W-1:0] lat_base_reg;
    logic [DENS_W-1:0] own_reg;
    logic [55:0]      pa_reg, pb_reg;
    logic [S_W-1:0]   s_reg;
    logic [55:0]      d_reg;
    logic [63:0]      v_reg, root_reg, bit_reg;
    logic [5:0]       step_reg;
    logic [35:0]      g_reg;
    logic [63:0]      plo_reg;
    logic [47:0]      phi_reg;
    logic             sat_reg;
    logic [3:0]       sys_reg;
    logic             last_reg;
    logic             out_v_reg;
    logic [31:0]      out_val_reg;
    logic             out_sat_reg, out_last_reg;
    logic [3:0]       out_sys_reg;

    logic [56:0] s_full;
    logic [63:0] trial;
    logic [51:0] g_full;
    logic [84:0] res_full;

    assign job_ready = st_reg == ST_IDLE;
    assign s_full    = {1'b0, pa_reg} + {1'b0, pb_reg};
    assign trial     = root_reg + bit_reg;
    assign g_full    = 52'(cfg.modulus_mpa) * 52'(cfg.burgers_vec);
    assign res_full  = ({21'd0, phi_reg, 16'd0} + {21'd0, plo_reg}) >> 16;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (job_valid) st_next = ST_M1;
            ST_M1:   st_next = ST_M2;
            ST_M2:   st_next = ST_SUM;
            ST_SUM:  st_next = ST_D;
            ST_D:    st_next = ST_D2;
            ST_D2:   st_next = ST_SQ;
            ST_SQ:   if (step_reg == 6'd32) st_next = ST_G;
            ST_G:    st_next = ST_R;
            ST_R:    st_next = ST_OUT;
            ST_OUT:  if (!out_v_reg || res_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (res_valid && res_ready) out_v_reg <= 1'b0;
            if (st_reg == ST_OUT && (!out_v_reg || res_ready)) out_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            ST_IDLE: begin
                lat_base_reg <= job.total - TOT_W'(job.own);
                own_reg      <= job.own;
                sys_reg      <= job.sys;
                last_reg     <= job.last;
            end
            ST_M1: begin
                pa_reg <= 56'({17'd0, lat_base_reg} * cfg.latent_factor);
                pb_reg <= 56'({23'd0, own_reg} * cfg.self_factor);
            end
            ST_M2: ;
            ST_SUM: begin
                sat_reg <= s_full > 57'({S_W{1'b1}});
                s_reg   <= (s_full > 57'({S_W{1'b1}})) ? {S_W{1'b1}} : S_W'(s_full);
            end
            ST_D: begin
                // 48x16 product in two 24-bit halves
                plo_reg <= 64'(s_reg[23:0] * cfg.barrier_factor);
                phi_reg <= 48'(s_reg[47:24] * cfg.barrier_factor);
            end
            ST_D2: begin
                d_reg    <= 56'((({24'd0, phi_reg[39:0]} << 24)
                                 + {24'd0, plo_reg[39:0]}) >> 8);
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
                step_reg <= '0;
            end
            ST_SQ: begin
                if (step_reg == 6'd0) v_reg <= {8'd0, d_reg};
                if (step_reg != 6'd0) begin
                    if (v_reg >= trial) begin
                        v_reg    <= v_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                step_reg <= step_reg + 1'b1;
            end
            ST_G: begin
                g_reg <= g_full[51:16];
            end
            ST_R: begin
                // g (36 bits) times root (28 bits), split into halves
                plo_reg <= 64'({28'd0, g_reg} * root_reg[15:0]);
                phi_reg <= 48'({12'd0, g_reg} * root_reg[31:16]);
            end
            ST_OUT: begin
                if (!out_v_reg || res_ready) begin
                    out_val_reg  <= (res_full > 85'hFFFFFFFF) ? 32'hFFFFFFFF
                                                               : res_full[31:0];
                    out_sat_reg  <= sat_reg || (res_full > 85'hFFFFFFFF);
                    out_sys_reg  <= sys_reg;
                    out_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign res_valid = out_v_reg;
    assign res_value = out_val_reg;
    assign res_sat   = out_sat_reg;
    assign res_sys   = out_sys_reg;
    assign res_last  = out_last_reg;
endmodule
`default_nettype wire

@@ tb/taylor_slip_resistance_core_tb.sv @@
// Self-checking testbench for the Taylor slip resistance core, with a built-in predictor.
`default_nettype none
module taylor_slip_resistance_core_tb;
    import tsr_pkg::*;

    localparam int unsigned SLIPS = NUM_SLIP_DEF;
    localparam int unsigned SETTLE = 600;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct {
        logic [31:0] mobile;
        logic [31:0] immobile;
        logic        last;
    } slip_word_t;

    typedef struct {
        logic [3:0]  sys;
        logic [31:0] resistance;
        logic        saturated;
        logic        last;
    } resist_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0; // mobile, immobile
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata; // slip_system, resistance, saturated
    logic m_axis_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    taylor_slip_resistance_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] self_f, latent_f, barrier_f;
    logic [19:0] modulus_p;
    logic [31:0] burgers;
    logic [32:0] dens_store [SLIPS];
    logic [63:0] dens_total;
    int unsigned load_cnt;

    slip_word_t slip_word_q[$];
    resist_t resist_q[$];
    int unsigned errors = 0;
    bit calm = 1'b0;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] root, bits;
        root = '0;
        bits = 64'd1 << 62;
        while (bits > v) bits = bits >> 2;
        while (bits != 0) begin
            if (v >= root + bits) begin
                v = v - (root + bits);
                root = (root >> 1) + bits;
            end else begin
                root = root >> 1;
            end
            bits = bits >> 2;
        end
        return root;
    endfunction

    task automatic predict_resistance(input slip_word_t w);
        logic [63:0] g, own, s, d, r, res;
        resist_t e;
        if (load_cnt < SLIPS) begin
            dens_store[load_cnt] = {1'b0, w.mobile} + {1'b0, w.immobile};
            dens_total = dens_total + dens_store[load_cnt];
            load_cnt++;
        end
        if (w.last) begin
            g = (64'(modulus_p) * 64'(burgers)) >> 16;
            for (int i = 0; i < SLIPS; i++) begin
                own = (i < load_cnt) ? 64'(dens_store[i]) : 64'd0;
                s = 64'(latent_f) * (dens_total - own) + 64'(self_f) * own;
                e.saturated = 1'b0;
                if (s > 64'h0000_FFFF_FFFF_FFFF) begin
                    s = 64'h0000_FFFF_FFFF_FFFF;
                    e.saturated = 1'b1;
                end
                d = (s * 64'(barrier_f)) >> 8;
                r = isqrt(d);
                // the 64-bit product cannot wrap: g fits in 36 bits and the root in 28 bits
                res = (g * r) >> 16;
                if (res > 64'hFFFF_FFFF) begin
                    res = 64'hFFFF_FFFF;
                    e.saturated = 1'b1;
                end
                e.sys = 4'(i);
                e.resistance = res[31:0];
                e.last = (i == SLIPS - 1);
                resist_q.push_back(e);
            end
            dens_total = '0;
            load_cnt = 0;
        end
    endtask

    // driver
    int unsigned s_gap = 0;
    always @(posedge aclk) begin
        slip_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (slip_word_q.size() > 0) begin
                w = slip_word_q.pop_front();
                s_axis_tdata <= {w.immobile, w.mobile};
                s_axis_tlast <= w.last;
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 9) < 3)
                    s_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off once a set ends with more words queued
    int unsigned m_gap = 0;
    int unsigned hold_left = 0;
    bit held = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (!held && s_axis_tvalid && s_axis_tready && s_axis_tlast
                     && slip_word_q.size() > 0) begin
            held <= 1'b1;
            hold_left <= 3000;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) < 3)
                m_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        end
    end

    // monitor: predict on accepted input words, check accepted results
    always @(posedge aclk) begin
        slip_word_t w;
        resist_t e;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            w.mobile = s_axis_tdata[31:0];
            w.immobile = s_axis_tdata[63:32];
            w.last = s_axis_tlast;
            predict_resistance(w);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (resist_q.size() == 0) begin
                $error("unexpected result word, tdata %h", m_axis_tdata);
                errors++;
            end else begin
                e = resist_q.pop_front();
                if (m_axis_tdata[3:0] !== e.sys) begin
                    $error("slip_system: expected %0d, got %0d", e.sys, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[35:4] !== e.resistance) begin
                    $error("resistance: expected %h, got %h", e.resistance,
                           m_axis_tdata[35:4]);
                    errors++;
                end
                if (m_axis_tdata[36] !== e.saturated) begin
                    $error("saturated: expected %b, got %b", e.saturated, m_axis_tdata[36]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_result: expected %b, got %b", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_SELF:    self_f = val[15:0];
            REG_LATENT:  latent_f = val[15:0];
            REG_BARRIER: barrier_f = val[15:0];
            REG_SHEAR:   modulus_p = val[19:0];
            REG_BURGERS: burgers = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] sf, input logic [15:0] lf,
                            input logic [15:0] bf, input logic [19:0] sm,
                            input logic [31:0] bl);
        write_reg(REG_SELF, {16'($urandom), sf});
        write_reg(REG_LATENT, 32'(lf));
        write_reg(REG_BARRIER, 32'(bf));
        write_reg(REG_SHEAR, {12'($urandom), sm});
        write_reg(REG_BURGERS, bl);
    endtask

    task automatic wait_idle();
        wait (slip_word_q.size() == 0 && !s_axis_tvalid && resist_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_dens();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // mode 0 random, 1 all zero, 2 all max
    task automatic push_set(input int unsigned n, input int unsigned mode);
        slip_word_t w;
        @(negedge aclk);
        for (int i = 0; i < n; i++) begin
            w.mobile = (mode == 1) ? '0 : (mode == 2) ? '1 : rand_dens();
            w.immobile = (mode == 1) ? '0 : (mode == 2) ? '1 : rand_dens();
            w.last = (i == n - 1);
            slip_word_q.push_back(w);
        end
    endtask

    task automatic random_sets(input int unsigned nsets);
        for (int k = 0; k < nsets; k++)
            push_set(($urandom_range(0, 9) < 7) ? SLIPS : $urandom_range(1, SLIPS + 3), 0);
    endtask

    initial begin
        self_f = SELF_RST;
        latent_f = LATENT_RST;
        barrier_f = BARRIER_RST;
        modulus_p = SHEAR_RST;
        burgers = '0;
        dens_total = '0;
        load_cnt = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults, burgers zero gives zero resistance
        push_set(SLIPS, 2);
        wait_idle();

        // typical values, directed sets; the long receiver hold-off falls here
        set_regs(16'd4096, 16'd819, 16'd1229, 20'd79731, 32'd1073742);
        write_reg(IDX_SPARE_LO, 32'hFFFF_FFFF); // out of range, ignore
        write_reg(IDX_SPARE_HI, 32'h1234_5678);
        push_set(SLIPS, 1);
        push_set(3, 0);
        push_set(1, 2);
        push_set(SLIPS + 2, 0);
        wait_idle();

        // all registers at maximum: clipping on both stages
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
        push_set(SLIPS, 2);
        random_sets(1);
        wait_idle();

        // all registers zero
        set_regs('0, '0, '0, '0, '0);
        random_sets(1);
        wait_idle();

        // random phases, the second without gaps
        for (int p = 0; p < 2; p++) begin
            calm = (p == 1);
            set_regs(16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom),
                     $urandom);
            random_sets(1);
            wait_idle();
        end
        calm = 1'b0;
        set_regs(16'($urandom_range(0, 8192)), 16'($urandom_range(0, 2048)),
                 16'($urandom_range(0, 8192)), 20'($urandom_range(20000, 200000)),
                 $urandom_range(0, 32'h0100_0000));
        random_sets(1);
        wait_idle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
